// File: hw/rtl/pmlp_pkg.sv
package pmlp_pkg;

    // table geometry
    localparam int TABLE_BITS = 10;
    localparam int NUM_SLOTS  = 1 << TABLE_BITS;
    localparam int PAGE_SHIFT = 12;

    // field widths
    localparam int KEY_W    = 36;
    localparam int KEY_HI_W = KEY_W - 32;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 3;

    // murmur3 finalizer half
    localparam int          MIX_SHIFT   = 33;
    localparam logic [31:0] MIX_MULT_LO = 32'hed558ccd;
    localparam logic [31:0] MIX_MULT_HI = 32'hff51afd7;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO = 3'd4;

    // operation codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // classified item handed from front to back
    typedef struct packed {
        logic                  func;
        logic [KEY_W-1:0]      key;
        logic [HANDLE_W-1:0]   handle;
        logic [TABLE_BITS-1:0] slot;
        logic                  zero;
    } pmlp_req_t;

endpackage

// File: hw/rtl/pmlp_ram.sv
module pmlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port (read before write)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/pmlp_front.sv
module pmlp_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [pmlp_pkg::KEY_W-1:0]    page_number,
    input  logic [pmlp_pkg::HANDLE_W-1:0] handle,
    input  logic                         clear_busy,
    output logic                         q_push,
    output pmlp_pkg::pmlp_req_t          q_entry,
    input  logic                         q_full
);

    import pmlp_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL0,
        F_MUL1,
        F_MUL2,
        F_PUSH
    } front_state_t;

    front_state_t        state_reg;
    logic                func_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                zero_reg;
    logic [KEY_W-1:0]    x1_reg;
    logic [63:0]         pp_lo_reg;
    logic [31:0]         hi_reg;
    logic [63:0]         prod_reg;

    logic                in_take;
    logic [KEY_W-1:0]    x1_in;
    logic [63:0]         pp0;
    logic [31:0]         pp1;
    logic [31:0]         pp2;
    logic [63:0]         mixed;

    assign in_stall = (state_reg != F_IDLE) || clear_busy;
    assign in_take  = in_valid && !in_stall;
    assign x1_in    = page_number ^ (page_number >> MIX_SHIFT);

    // partial products of the 64-bit multiply, one per cycle
    assign pp0 = {32'b0, x1_reg[31:0]} * {32'b0, MIX_MULT_LO};
    assign pp1 = x1_reg[31:0] * MIX_MULT_HI;
    assign pp2 = {{(32-KEY_HI_W){1'b0}}, x1_reg[KEY_W-1:32]} * MIX_MULT_LO;

    // final xor-shift and slot select
    assign mixed = prod_reg ^ (prod_reg >> MIX_SHIFT);

    assign q_push          = (state_reg == F_PUSH) && !q_full;
    assign q_entry.func    = func_reg;
    assign q_entry.key     = key_reg;
    assign q_entry.handle  = handle_reg;
    assign q_entry.slot    = zero_reg ? '0 : mixed[TABLE_BITS-1:0];
    assign q_entry.zero    = zero_reg;

    // accept, hash sequencer, hand-off to queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_take)
                    begin
                        func_reg   <= func;
                        key_reg    <= page_number;
                        handle_reg <= handle;
                        x1_reg     <= x1_in;
                        zero_reg   <= (page_number == '0);
                        state_reg  <= (page_number == '0) ? F_PUSH : F_MUL0;
                    end
                end
                F_MUL0:
                begin
                    pp_lo_reg <= pp0;
                    state_reg <= F_MUL1;
                end
                F_MUL1:
                begin
                    hi_reg    <= pp1;
                    state_reg <= F_MUL2;
                end
                F_MUL2:
                begin
                    prod_reg  <= {pp_lo_reg[63:32] + hi_reg + pp2, pp_lo_reg[31:0]};
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/pmlp_queue.sv
module pmlp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pmlp_pkg::pmlp_req_t push_entry,
    output logic                full,
    input  logic                pop,
    output pmlp_pkg::pmlp_req_t head,
    output logic                empty
);

    import pmlp_pkg::*;

    pmlp_req_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/pmlp_back.sv
module pmlp_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pmlp_pkg::pmlp_req_t            q_head,
    input  logic                           q_empty,
    output logic                           q_pop,
    output logic                           clear_busy,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pmlp_pkg::STATUS_W-1:0]  status,
    output logic [pmlp_pkg::HANDLE_W-1:0]  handle_out
);

    import pmlp_pkg::*;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_DONE
    } back_state_t;

    localparam logic [TABLE_BITS-1:0] SLOT_LAST = '1;

    back_state_t           state_reg;
    logic [TABLE_BITS-1:0] clr_cnt_reg;
    pmlp_req_t             req_reg;
    logic [TABLE_BITS-1:0] slot_reg;
    logic [TABLE_BITS-1:0] probe_cnt_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [HANDLE_W-1:0]   res_handle_reg;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [HANDLE_W-1:0]   handle_out_reg;

    logic [TABLE_BITS-1:0] rd_addr;
    logic [KEY_W-1:0]      key_rd;
    logic [HANDLE_W-1:0]   handle_rd;
    logic                  key_we;
    logic [TABLE_BITS-1:0] key_wa;
    logic [KEY_W-1:0]      key_wd;
    logic                  handle_we;
    logic                  slot_match;
    logic                  slot_empty;
    logic                  out_free;

    assign clear_busy = (state_reg == B_CLEAR);
    assign q_pop      = (state_reg == B_IDLE) && !q_empty;
    assign slot_match = (key_rd == req_reg.key);
    assign slot_empty = (key_rd == '0);
    assign out_free   = !out_valid_reg || !out_stall;

    // read the first slot on pop, the next slot while probing
    assign rd_addr = (state_reg == B_PROBE) ? slot_reg + 1'b1 : q_head.slot;

    // key writes: clearing pass or claim of an empty slot
    always_comb
    begin
        key_we = 1'b0;
        key_wa = slot_reg;
        key_wd = req_reg.key;
        if (state_reg == B_CLEAR)
        begin
            key_we = 1'b1;
            key_wa = clr_cnt_reg;
            key_wd = '0;
        end
        else if (state_reg == B_PROBE)
        begin
            key_we = (req_reg.func == FUNC_INSERT) && !slot_match && slot_empty;
        end
    end

    // handle writes on update or new insert
    assign handle_we = (state_reg == B_PROBE) && (req_reg.func == FUNC_INSERT)
                       && (slot_match || slot_empty);

    pmlp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (NUM_SLOTS)
    ) u_key_ram (
        .clk     (clk),
        .we      (key_we),
        .wr_addr (key_wa),
        .wr_data (key_wd),
        .rd_addr (rd_addr),
        .rd_data (key_rd)
    );

    pmlp_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (NUM_SLOTS)
    ) u_handle_ram (
        .clk     (clk),
        .we      (handle_we),
        .wr_addr (slot_reg),
        .wr_data (req_reg.handle),
        .rd_addr (rd_addr),
        .rd_data (handle_rd)
    );

    // clear, probe sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != B_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == SLOT_LAST)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        req_reg       <= q_head;
                        slot_reg      <= q_head.slot;
                        probe_cnt_reg <= '0;
                        if (q_head.zero)
                        begin
                            res_status_reg <= ST_ZERO;
                            res_handle_reg <= '0;
                            state_reg      <= B_DONE;
                        end
                        else
                        begin
                            state_reg <= B_PROBE;
                        end
                    end
                end
                B_PROBE:
                begin
                    if (slot_match)
                    begin
                        res_status_reg <= ST_HIT;
                        res_handle_reg <= (req_reg.func == FUNC_LOOKUP) ? handle_rd : '0;
                        state_reg      <= B_DONE;
                    end
                    else if (slot_empty)
                    begin
                        res_status_reg <= (req_reg.func == FUNC_LOOKUP) ? ST_MISS : ST_NEW;
                        res_handle_reg <= '0;
                        state_reg      <= B_DONE;
                    end
                    else if (probe_cnt_reg == SLOT_LAST)
                    begin
                        res_status_reg <= (req_reg.func == FUNC_LOOKUP) ? ST_MISS : ST_FULL;
                        res_handle_reg <= '0;
                        state_reg      <= B_DONE;
                    end
                    else
                    begin
                        slot_reg      <= slot_reg + 1'b1;
                        probe_cnt_reg <= probe_cnt_reg + 1'b1;
                    end
                end
                B_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_reg     <= res_status_reg;
                        handle_out_reg <= res_handle_reg;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign handle_out = handle_out_reg;

endmodule

// File: hw/rtl/page_map_linear_probe_table_top.sv
// the front takes an item, forms three partial products in turn and pushes it to the queue;
// the back pops the queue, probes one slot after another and loads the output register; a zero key
// skips hashing and probing
// the front and the back each take a new item only once they are through with the last one
// reset: a clearing pass writes each of the 2^TABLE_BITS (1024) key slots to empty, with
// in_stall held high; the handle store is not cleared
module page_map_linear_probe_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [pmlp_pkg::KEY_W-1:0]    page_number,
    input  logic [pmlp_pkg::HANDLE_W-1:0] handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pmlp_pkg::STATUS_W-1:0] status,
    output logic [pmlp_pkg::HANDLE_W-1:0] handle_out
);

    import pmlp_pkg::*;

    logic      clear_busy;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    pmlp_req_t q_entry;
    pmlp_req_t q_head;

    // hash and classify
    pmlp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .page_number (page_number),
        .handle      (handle),
        .clear_busy  (clear_busy),
        .q_push      (q_push),
        .q_entry     (q_entry),
        .q_full      (q_full)
    );

    // decoupling queue
    pmlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    // probe engine and tables
    pmlp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .handle_out (handle_out)
    );

    // a nonzero handle only comes with a hit
    a_handle_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (handle_out != '0)) |-> (status == ST_HIT))
        else $error("nonzero handle_out on a non-hit result");

    // the front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    // the back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // no item is taken during the clearing pass
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !q_pop)
        else $error("item popped during clearing pass");

endmodule
